FILE: design/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared constants, command and result codes, and payload types.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   localparam int FONT_W     = 8;
   localparam int FONT_H     = 16;
   localparam int GLYPHS     = 256;
   localparam int STORE_AW   = 12;
   localparam int ROW_IDX_W  = (FONT_H > 1) ? $clog2(FONT_H) : 1;

   // Command codes of an input item.
   localparam logic [1:0] CMD_PUT_CHAR   = 2'd0;
   localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
   localparam logic [1:0] CMD_LOAD_FONT  = 2'd2;
   localparam logic [1:0] CMD_CLEAR      = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_GLYPH  = 2'd0;
   localparam logic [1:0] KIND_SCROLL = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // Control characters.
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TEXT_COLS      = 3'd0;
   localparam logic [2:0] CSR_TEXT_ROWS      = 3'd1;
   localparam logic [2:0] CSR_FORE_COLOR     = 3'd2;
   localparam logic [2:0] CSR_BACK_COLOR     = 3'd3;
   localparam logic [2:0] CSR_DISPLAY_ENABLE = 3'd4;

   localparam logic [5:0] SCROLL_LINES = 6'(FONT_H);

   typedef struct packed {
      logic [1:0]          cmd;
      logic [7:0]          char_code;
      logic                force_req;
      logic [7:0]          cursor_col;
      logic [7:0]          cursor_row;
      logic [STORE_AW-1:0] font_addr;
      logic [7:0]          font_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  row_bits;
      logic [31:0] fg_out;
      logic [31:0] bg_out;
      logic [5:0]  scroll_lines;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  text_cols;
      logic [7:0]  text_rows;
      logic [31:0] fore_color;
      logic [31:0] back_color;
      logic        display_enable;
   } cfg_type;

   // Glyph store access issued by the sequencer.
   typedef struct packed {
      logic                wr_en;
      logic [STORE_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic                rd_en;
      logic [STORE_AW-1:0] rd_addr;
   } mem_req_type;

   // One result waiting for its glyph store read data.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic        last;
   } pend_type;

endpackage

FILE: design/tcgr_glyph_ram.sv
// ----------------------------------------------------------------------------
// Glyph store
// 4096 x 8 synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcgr_glyph_ram (
   input  logic                  clock,
   input  tcgr_pkg::mem_req_type mem_req,
   output logic [7:0]            rd_data
);

   logic [7:0] mem_ff [2**tcgr_pkg::STORE_AW];
   logic [7:0] rd_data_ff;

   // The read register only changes on a read, so data waiting for the
   // output stage stays put.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tcgr_seq.sv
// ----------------------------------------------------------------------------
// Text console sequencer
// Decodes items, keeps the cursor, walks the glyph rows and issues results.
// ----------------------------------------------------------------------------
module tcgr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcgr_pkg::req_type     req_payload,
   input  tcgr_pkg::cfg_type     cfg,
   input  logic                  pend_move,
   output tcgr_pkg::pend_type    pend,
   output tcgr_pkg::mem_req_type mem_req
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ROWS   = 3'b010,
      ST_SCROLL = 3'b100
   } seq_state_type;

   localparam logic [tcgr_pkg::ROW_IDX_W-1:0] LAST_ROW =
      tcgr_pkg::ROW_IDX_W'(tcgr_pkg::FONT_H - 1);

   seq_state_type                      state_ff, state_in;
   logic [7:0]                         cur_col_ff, cur_col_in;
   logic [7:0]                         cur_row_ff, cur_row_in;
   logic [tcgr_pkg::ROW_IDX_W-1:0]     row_idx_ff, row_idx_in;
   logic                               scroll_ff, scroll_in;
   logic [tcgr_pkg::STORE_AW-1:0]      base_addr_ff, base_addr_in;
   logic [11:0]                        base_x_ff, base_x_in;
   logic [11:0]                        base_y_ff, base_y_in;
   tcgr_pkg::pend_type                 pend_ff, pend_in;

   logic       accept;
   logic       pend_free;
   logic [7:0] cols_eff;
   logic [7:0] rows_eff;
   logic       print_en;
   logic       is_cr;
   logic       is_lf;
   logic [8:0] col0, row0, col1, row1, row2;
   logic       do_scroll;
   logic [7:0] glyph;

   assign cols_eff  = (cfg.text_cols == 8'd0) ? 8'd1 : cfg.text_cols;
   assign rows_eff  = (cfg.text_rows == 8'd0) ? 8'd1 : cfg.text_rows;
   assign pend_free = !pend_ff.valid || pend_move;
   assign req_stall = !((state_ff == ST_IDLE) && pend_free);
   assign accept    = req_valid && !req_stall;
   assign print_en  = cfg.display_enable || req_payload.force_req;
   assign is_cr     = (req_payload.char_code == tcgr_pkg::CHAR_CR);
   assign is_lf     = (req_payload.char_code == tcgr_pkg::CHAR_LF);

   // Cursor movement of a printed character, wrap and scroll included.
   always_comb begin
      if (is_cr) begin
         col0 = 9'd0;
         row0 = {1'b0, cur_row_ff};
      end else if (is_lf) begin
         col0 = 9'd0;
         row0 = {1'b0, cur_row_ff} + 9'd1;
      end else begin
         col0 = {1'b0, cur_col_ff} + 9'd1;
         row0 = {1'b0, cur_row_ff};
      end
      if (col0 >= {1'b0, cols_eff}) begin
         col1 = 9'd0;
         row1 = row0 + 9'd1;
      end else begin
         col1 = col0;
         row1 = row0;
      end
      do_scroll = (row1 >= {1'b0, rows_eff});
      row2      = do_scroll ? ({1'b0, rows_eff} - 9'd1) : row1;
   end

   // Codes past the font would fold back once; 8-bit codes stay below GLYPHS.
   always_comb begin
      if ({1'b0, req_payload.char_code} >= 9'(tcgr_pkg::GLYPHS)) begin
         glyph = 8'({1'b0, req_payload.char_code} - 9'(tcgr_pkg::GLYPHS));
      end else begin
         glyph = req_payload.char_code;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      row_idx_in   = row_idx_ff;
      scroll_in    = scroll_ff;
      base_addr_in = base_addr_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      pend_in      = pend_ff;
      if (pend_move) begin
         pend_in.valid = 1'b0;
      end
      mem_req         = '0;
      mem_req.wr_addr = req_payload.font_addr;
      mem_req.wr_data = req_payload.font_byte;
      mem_req.rd_addr = base_addr_ff + tcgr_pkg::STORE_AW'(row_idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.cmd)
                  tcgr_pkg::CMD_SET_CURSOR: begin
                     cur_col_in = (req_payload.cursor_col < cols_eff) ?
                                  req_payload.cursor_col : cols_eff - 8'd1;
                     cur_row_in = (req_payload.cursor_row < rows_eff) ?
                                  req_payload.cursor_row : rows_eff - 8'd1;
                  end
                  tcgr_pkg::CMD_LOAD_FONT: begin
                     mem_req.wr_en = 1'b1;
                  end
                  tcgr_pkg::CMD_CLEAR: begin
                     pend_in.valid   = 1'b1;
                     pend_in.kind    = tcgr_pkg::KIND_CLEAR;
                     pend_in.pixel_x = 12'd0;
                     pend_in.pixel_y = 12'd0;
                     pend_in.last    = 1'b1;
                  end
                  tcgr_pkg::CMD_PUT_CHAR: begin
                     if (print_en) begin
                        cur_col_in = col1[7:0];
                        cur_row_in = row2[7:0];
                        if (!is_cr && !is_lf) begin
                           // The glyph is drawn at the cursor before the move.
                           base_addr_in = tcgr_pkg::STORE_AW'(
                              20'(glyph) * 20'(tcgr_pkg::FONT_H));
                           base_x_in  = 12'(20'(cur_col_ff) * 20'(tcgr_pkg::FONT_W));
                           base_y_in  = 12'(20'(cur_row_ff) * 20'(tcgr_pkg::FONT_H));
                           row_idx_in = '0;
                           scroll_in  = do_scroll;
                           state_in   = ST_ROWS;
                        end else if (do_scroll) begin
                           pend_in.valid   = 1'b1;
                           pend_in.kind    = tcgr_pkg::KIND_SCROLL;
                           pend_in.pixel_x = 12'd0;
                           pend_in.pixel_y = 12'd0;
                           pend_in.last    = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROWS: begin
            if (pend_free) begin
               mem_req.rd_en   = 1'b1;
               pend_in.valid   = 1'b1;
               pend_in.kind    = tcgr_pkg::KIND_GLYPH;
               pend_in.pixel_x = base_x_ff;
               pend_in.pixel_y = base_y_ff + 12'(row_idx_ff);
               pend_in.last    = (row_idx_ff == LAST_ROW) && !scroll_ff;
               row_idx_in      = tcgr_pkg::ROW_IDX_W'(row_idx_ff + 1'b1);
               if (row_idx_ff == LAST_ROW) begin
                  state_in = scroll_ff ? ST_SCROLL : ST_IDLE;
               end
            end
         end
         ST_SCROLL: begin
            if (pend_free) begin
               pend_in.valid   = 1'b1;
               pend_in.kind    = tcgr_pkg::KIND_SCROLL;
               pend_in.pixel_x = 12'd0;
               pend_in.pixel_y = 12'd0;
               pend_in.last    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The held result lives in one register; only its valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_col_ff    <= 8'd0;
         cur_row_ff    <= 8'd0;
         pend_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         pend_ff.valid <= pend_in.valid;
      end
      pend_ff.kind    <= pend_in.kind;
      pend_ff.pixel_x <= pend_in.pixel_x;
      pend_ff.pixel_y <= pend_in.pixel_y;
      pend_ff.last    <= pend_in.last;
   end

   always_ff @(posedge clock) begin
      row_idx_ff      <= row_idx_in;
      scroll_ff       <= scroll_in;
      base_addr_ff    <= base_addr_in;
      base_x_ff       <= base_x_in;
      base_y_ff       <= base_y_in;
   end

   assign pend = pend_ff;

endmodule

FILE: design/text_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Character-cell console that turns text items into glyph row transfers.
// ----------------------------------------------------------------------------
// A printed character is taken in the idle state; then its FONT_H glyph
// rows follow at one per cycle while the output does not stall, set by the
// single read port of the glyph store. A character that runs past the bottom
// row adds a scroll request after its rows. CR, LF, clear, set-cursor and
// font load items are done in the idle state as they are taken. Every glyph
// row read goes through a one entry holding stage and an output register, so
// rows keep flowing at one per cycle while the consumer takes them, and the
// next item is taken while the final result of the previous one still waits
// in the output register. The glyph store holds 4096 font bytes with no
// reset; only bytes that were loaded may be drawn. Configuration must be
// written by the user only while no transfer is outstanding (unenforced).
// ----------------------------------------------------------------------------
module text_console_glyph_renderer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcgr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcgr_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   tcgr_pkg::cfg_type     cfg_ff;
   tcgr_pkg::rsp_type     rsp_payload_ff, rsp_payload_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tcgr_pkg::pend_type    pend;
   tcgr_pkg::mem_req_type mem_req;
   logic [7:0]            rd_data;
   logic                  pend_move;

   // Configuration registers. Writes past the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_cols      <= 8'd40;
         cfg_ff.text_rows      <= 8'd30;
         cfg_ff.fore_color     <= 32'h00FF_FFFF;
         cfg_ff.back_color     <= 32'd0;
         cfg_ff.display_enable <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tcgr_pkg::CSR_TEXT_COLS:      cfg_ff.text_cols      <= csr_wdata[7:0];
            tcgr_pkg::CSR_TEXT_ROWS:      cfg_ff.text_rows      <= csr_wdata[7:0];
            tcgr_pkg::CSR_FORE_COLOR:     cfg_ff.fore_color     <= csr_wdata;
            tcgr_pkg::CSR_BACK_COLOR:     cfg_ff.back_color     <= csr_wdata;
            tcgr_pkg::CSR_DISPLAY_ENABLE: cfg_ff.display_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   tcgr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .pend_move   (pend_move),
      .pend        (pend),
      .mem_req     (mem_req)
   );

   tcgr_glyph_ram u_glyph_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // The held result moves into the output register when that register is
   // empty or its transfer completes in this cycle.
   assign pend_move = pend.valid && (!rsp_valid_ff || !rsp_stall);

   // Fields that a result kind does not use are driven to zero.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_move) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.kind         = pend.kind;
         rsp_payload_in.pixel_x      = pend.pixel_x;
         rsp_payload_in.pixel_y      = pend.pixel_y;
         rsp_payload_in.last         = pend.last;
         rsp_payload_in.bg_out       = cfg_ff.back_color;
         rsp_payload_in.row_bits     = 8'd0;
         rsp_payload_in.fg_out       = 32'd0;
         rsp_payload_in.scroll_lines = 6'd0;
         if (pend.kind == tcgr_pkg::KIND_GLYPH) begin
            rsp_payload_in.row_bits = rd_data;
            rsp_payload_in.fg_out   = cfg_ff.fore_color;
         end
         if (pend.kind == tcgr_pkg::KIND_SCROLL) begin
            rsp_payload_in.scroll_lines = tcgr_pkg::SCROLL_LINES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: design/tcgr_checker.sv
// ----------------------------------------------------------------------------
// Text console result checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tcgr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tcgr_pkg::rsp_type rsp_payload
);

   // A result that is held back stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Only the three defined kinds leave the block.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.kind == tcgr_pkg::KIND_GLYPH ||
                     rsp_payload.kind == tcgr_pkg::KIND_SCROLL ||
                     rsp_payload.kind == tcgr_pkg::KIND_CLEAR))
      else $error("undefined result kind");

   // A scroll request is always the final result and carries the font height.
   a_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == tcgr_pkg::KIND_SCROLL |->
         rsp_payload.last && rsp_payload.row_bits == 8'd0 &&
         rsp_payload.scroll_lines == tcgr_pkg::SCROLL_LINES)
      else $error("malformed scroll request");

   // Glyph rows never carry a scroll height.
   a_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == tcgr_pkg::KIND_GLYPH |->
         rsp_payload.scroll_lines == 6'd0)
      else $error("glyph row carries scroll lines");

endmodule

bind text_console_glyph_renderer tcgr_checker u_checker (.*);
